### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms with synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// Types, widths, constants and saturating adders for pole containment.
// ----------------------------------------------------------------------------
package ppc_pkg;

  localparam int LON_W      = 26;
  localparam int LAT_W      = 24;
  localparam int TOL_W      = 24;
  localparam int DELTA_W    = LON_W + 2;
  localparam int SPAN_W     = 25;
  localparam int MAG_W      = SPAN_W - 1;
  localparam int LSUM_W     = LAT_W + 1;
  localparam int TERM_W     = 2 * SPAN_W;
  localparam int SPAN_SUM_W = 48;
  localparam int AREA_W     = 64;

  localparam logic signed [DELTA_W-1:0] HALF_TURN = 28'sd11796480;
  localparam logic signed [DELTA_W-1:0] FULL_TURN = 28'sd23592960;

  localparam logic [TOL_W-1:0] TOL_RESET = 24'd65536;

  localparam logic signed [SPAN_SUM_W-1:0] SPAN_SUM_MAX = {1'b0, {(SPAN_SUM_W-1){1'b1}}};
  localparam logic signed [SPAN_SUM_W-1:0] SPAN_SUM_MIN = {1'b1, {(SPAN_SUM_W-1){1'b0}}};
  localparam logic signed [AREA_W-1:0]     AREA_MAX     = {1'b0, {(AREA_W-1){1'b1}}};
  localparam logic signed [AREA_W-1:0]     AREA_MIN     = {1'b1, {(AREA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    POLE_NONE  = 2'd0,
    POLE_NORTH = 2'd1,
    POLE_SOUTH = 2'd2
  } pole_code_t;

  // vertex operands of the running edge and of the closing edge
  typedef struct packed {
    logic signed [LON_W-1:0] prev_lon;
    logic signed [LAT_W-1:0] prev_lat;
    logic signed [LON_W-1:0] lon;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] first_lon;
    logic signed [LAT_W-1:0] first_lat;
    logic                    has_edge;
    logic                    last;
    logic                    single;
  } operand_t;

  // per-edge span and area terms
  typedef struct packed {
    logic signed [SPAN_W-1:0] span_a;
    logic signed [TERM_W-1:0] term_a;
    logic signed [SPAN_W-1:0] span_b;
    logic signed [TERM_W-1:0] term_b;
    logic                     has_edge;
    logic                     last;
    logic                     single;
  } edge_terms_t;

  // sums after the last running edge, closing edge still to add
  typedef struct packed {
    logic signed [SPAN_SUM_W-1:0] span_part;
    logic signed [AREA_W-1:0]     area_part;
    logic signed [SPAN_W-1:0]     span_b;
    logic signed [TERM_W-1:0]     term_b;
    logic                         single;
  } final_t;

  function automatic logic signed [SPAN_SUM_W-1:0] sat_span_add(
    logic signed [SPAN_SUM_W-1:0] acc,
    logic signed [SPAN_W-1:0]     inc
  );
    logic signed [SPAN_SUM_W:0] s;
    s = (SPAN_SUM_W+1)'(acc) + (SPAN_SUM_W+1)'(inc);
    if (s[SPAN_SUM_W] != s[SPAN_SUM_W-1]) begin
      return s[SPAN_SUM_W] ? SPAN_SUM_MIN : SPAN_SUM_MAX;
    end
    return s[SPAN_SUM_W-1:0];
  endfunction

  function automatic logic signed [AREA_W-1:0] sat_area_add(
    logic signed [AREA_W-1:0] acc,
    logic signed [TERM_W-1:0] inc
  );
    logic signed [AREA_W:0] s;
    s = (AREA_W+1)'(acc) + (AREA_W+1)'(inc);
    if (s[AREA_W] != s[AREA_W-1]) begin
      return s[AREA_W] ? AREA_MIN : AREA_MAX;
    end
    return s[AREA_W-1:0];
  endfunction

endpackage

### hw/rtl/ppc_vertex_if.sv
// ----------------------------------------------------------------------------
// ppc_vertex_if
// Valid/ready channel carrying one polygon vertex per item.
// ----------------------------------------------------------------------------
interface ppc_vertex_if;
  import ppc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [LON_W-1:0] longitude;
  logic signed [LAT_W-1:0] latitude;
  logic                    last_vertex;

  modport source (output valid, longitude, latitude, last_vertex, input ready);
  modport sink   (input valid, longitude, latitude, last_vertex, output ready);
endinterface

### hw/rtl/ppc_pole_if.sv
// ----------------------------------------------------------------------------
// ppc_pole_if
// Valid/ready channel carrying one pole verdict per item.
// ----------------------------------------------------------------------------
interface ppc_pole_if;
  import ppc_pkg::*;

  logic       valid;
  logic       ready;
  pole_code_t pole_code;

  modport source (output valid, pole_code, input ready);
  modport sink   (input valid, pole_code, output ready);
endinterface

### hw/rtl/ppc_edge_term.sv
// ----------------------------------------------------------------------------
// ppc_edge_term
// Wraps one edge to at most a half turn and forms its span and area term.
// ----------------------------------------------------------------------------
module ppc_edge_term (
  input  logic signed [ppc_pkg::LON_W-1:0]  start_lon,
  input  logic signed [ppc_pkg::LAT_W-1:0]  start_lat,
  input  logic signed [ppc_pkg::LON_W-1:0]  end_lon,
  input  logic signed [ppc_pkg::LAT_W-1:0]  end_lat,
  output logic signed [ppc_pkg::SPAN_W-1:0] span,
  output logic signed [ppc_pkg::TERM_W-1:0] term
);
  import ppc_pkg::*;

  logic signed [DELTA_W-1:0] delta;
  logic signed [DELTA_W-1:0] wrapped;
  logic signed [SPAN_W-1:0]  span_neg;
  logic        [MAG_W-1:0]   mag;
  logic signed [SPAN_W-1:0]  mag_s;
  logic signed [LSUM_W-1:0]  lat_sum;

  // end minus start; three full turns cover any 26-bit operand pair
  always_comb begin
    delta   = DELTA_W'(end_lon) - DELTA_W'(start_lon);
    wrapped = delta;
    if (delta > HALF_TURN) begin
      wrapped = wrapped - FULL_TURN;
      if (wrapped > HALF_TURN) wrapped = wrapped - FULL_TURN;
      if (wrapped > HALF_TURN) wrapped = wrapped - FULL_TURN;
    end else if (delta < -HALF_TURN) begin
      wrapped = wrapped + FULL_TURN;
      if (wrapped < -HALF_TURN) wrapped = wrapped + FULL_TURN;
      if (wrapped < -HALF_TURN) wrapped = wrapped + FULL_TURN;
    end
  end

  always_comb begin
    span     = SPAN_W'(-wrapped);
    span_neg = -span;
    mag      = span[SPAN_W-1] ? span_neg[MAG_W-1:0] : span[MAG_W-1:0];
    mag_s    = $signed({1'b0, mag});
    lat_sum  = LSUM_W'(start_lat) + LSUM_W'(end_lat);
    term     = TERM_W'(mag_s) * TERM_W'(lat_sum);
  end

endmodule

### hw/rtl/ppc_verdict.sv
// ----------------------------------------------------------------------------
// ppc_verdict
// Adds the closing edge and decides north, south or no pole.
// ----------------------------------------------------------------------------
module ppc_verdict (
  input  ppc_pkg::final_t          fin,
  input  logic [ppc_pkg::TOL_W-1:0] tol,
  output ppc_pkg::pole_code_t      code
);
  import ppc_pkg::*;

  logic signed [SPAN_SUM_W-1:0] span_total;
  logic signed [AREA_W-1:0]     area_total;
  logic signed [SPAN_SUM_W-1:0] tol_pos;
  logic signed [SPAN_SUM_W-1:0] tol_neg;

  always_comb begin
    span_total = sat_span_add(fin.span_part, fin.span_b);
    area_total = sat_area_add(fin.area_part, fin.term_b);
    tol_pos    = $signed({{(SPAN_SUM_W-TOL_W){1'b0}}, tol});
    tol_neg    = -tol_pos;
    if (fin.single) begin
      code = POLE_NONE;
    end else if (span_total < tol_pos && span_total > tol_neg) begin
      code = POLE_NONE;
    end else if (!area_total[AREA_W-1]) begin
      code = POLE_NORTH;
    end else begin
      code = POLE_SOUTH;
    end
  end

endmodule

### hw/rtl/polygon_pole_containment.sv
// ----------------------------------------------------------------------------
// polygon_pole_containment
// Streams lat-lon polygon vertices and reports which pole the ring encloses.
//
//   channel   dir  handshake      payload
//   vertex    in   valid/ready    longitude, latitude, last_vertex
//   pole      out  valid/ready    pole_code (one item per last_vertex)
//   cfg       in   cfg_wr_en      cfg_wr_data -> span_tolerance
//
// One vertex accepted per cycle unless stalled; a verdict is offered after its
// last vertex passes the operand, edge term, accumulate and output registers.
// Edge terms use two 25x25 multipliers in parallel, one per edge.
// rst (synchronous) empties the pipe, clears the sums and loads a tolerance
// of one degree. A stalled verdict holds back each stage behind it once the
// next stage is occupied; the vertex channel stalls when all four are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module polygon_pole_containment (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [ppc_pkg::TOL_W-1:0] cfg_wr_data,
  ppc_vertex_if.sink                vertex,
  ppc_pole_if.source                pole
);
  import ppc_pkg::*;

  logic [TOL_W-1:0] span_tolerance;

  // polygon state
  logic                         have_first;
  logic signed [LON_W-1:0]      first_lon;
  logic signed [LAT_W-1:0]      first_lat;
  logic signed [LON_W-1:0]      prev_lon;
  logic signed [LAT_W-1:0]      prev_lat;
  logic signed [SPAN_SUM_W-1:0] span_acc;
  logic signed [AREA_W-1:0]     area_acc;

  // pipeline registers
  logic        v0, v1, v2, out_valid;
  operand_t    r0;
  edge_terms_t r1;
  final_t      r2;
  pole_code_t  out_code;

  logic                         in_fire, free0, free1, free2, out_free;
  logic                         move0, move1, move2;
  operand_t                     r0_next;
  edge_terms_t                  r1_next;
  final_t                       r2_next;
  logic signed [SPAN_W-1:0]     run_span;
  logic signed [TERM_W-1:0]     run_term;
  logic signed [SPAN_W-1:0]     close_span;
  logic signed [TERM_W-1:0]     close_term;
  logic signed [SPAN_SUM_W-1:0] span_step;
  logic signed [AREA_W-1:0]     area_step;
  pole_code_t                   verdict;

  // ready ripples back from the output register; non-final items leave at the
  // accumulate stage
  always_comb begin
    out_free = !out_valid || pole.ready;
    free2    = !v2 || out_free;
    free1    = !v1 || free2;
    free0    = !v0 || free1;
    move0    = v0 && free1;
    move1    = v1 && free2;
    move2    = v2 && out_free;
    in_fire  = vertex.valid && free0;
  end

  assign vertex.ready   = free0;
  assign pole.valid     = out_valid;
  assign pole.pole_code = out_code;

  always_comb begin
    r0_next.prev_lon  = prev_lon;
    r0_next.prev_lat  = prev_lat;
    r0_next.lon       = vertex.longitude;
    r0_next.lat       = vertex.latitude;
    r0_next.first_lon = first_lon;
    r0_next.first_lat = first_lat;
    r0_next.has_edge  = have_first;
    r0_next.last      = vertex.last_vertex;
    r0_next.single    = !have_first && vertex.last_vertex;
  end

  ppc_edge_term u_edge_run (
    .start_lon (r0.prev_lon),
    .start_lat (r0.prev_lat),
    .end_lon   (r0.lon),
    .end_lat   (r0.lat),
    .span      (run_span),
    .term      (run_term)
  );

  ppc_edge_term u_edge_close (
    .start_lon (r0.lon),
    .start_lat (r0.lat),
    .end_lon   (r0.first_lon),
    .end_lat   (r0.first_lat),
    .span      (close_span),
    .term      (close_term)
  );

  always_comb begin
    r1_next.span_a   = run_span;
    r1_next.term_a   = run_term;
    r1_next.span_b   = close_span;
    r1_next.term_b   = close_term;
    r1_next.has_edge = r0.has_edge;
    r1_next.last     = r0.last;
    r1_next.single   = r0.single;
  end

  // add the running edge; the closing edge waits for the next stage
  always_comb begin
    if (r1.has_edge) begin
      span_step = sat_span_add(span_acc, r1.span_a);
      area_step = sat_area_add(area_acc, r1.term_a);
    end else begin
      span_step = span_acc;
      area_step = area_acc;
    end
    r2_next.span_part = span_step;
    r2_next.area_part = area_step;
    r2_next.span_b    = r1.span_b;
    r2_next.term_b    = r1.term_b;
    r2_next.single    = r1.single;
  end

  ppc_verdict u_verdict (
    .fin  (r2),
    .tol  (span_tolerance),
    .code (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      span_tolerance <= TOL_RESET;
      have_first     <= 1'b0;
      span_acc       <= '0;
      area_acc       <= '0;
      v0             <= 1'b0;
      v1             <= 1'b0;
      v2             <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) span_tolerance <= cfg_wr_data;
      if (in_fire) have_first <= !vertex.last_vertex;
      if (move1) begin
        span_acc <= r1.last ? '0 : span_step;
        area_acc <= r1.last ? '0 : area_step;
      end
      v0        <= in_fire || (v0 && !free1);
      v1        <= move0 || (v1 && !free2);
      v2        <= (move1 && r1.last) || (v2 && !out_free);
      out_valid <= move2 || (out_valid && !pole.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      r0       <= r0_next;
      prev_lon <= vertex.longitude;
      prev_lat <= vertex.latitude;
      if (!have_first) begin
        first_lon <= vertex.longitude;
        first_lat <= vertex.latitude;
      end
    end
    if (move0) r1 <= r1_next;
    if (move1) r2 <= r2_next;
    if (move2) out_code <= verdict;
  end

  `ASSERT_NEXT(a_sums_clear, clk, rst, move1 && r1.last, span_acc == '0 && area_acc == '0, "sums not cleared after last vertex")
  `ASSERT_NEXT(a_ring_restart, clk, rst, in_fire && vertex.last_vertex, !have_first, "ring not restarted after last vertex")
  `ASSERT_IMPLIES(a_single_none, clk, rst, v2 && r2.single, verdict == POLE_NONE, "single vertex ring reported a pole")
  `ASSERT_NEXT(a_result_held, clk, rst, out_valid && !pole.ready, out_valid && out_code == $past(out_code), "stalled verdict lost or changed")

endmodule
